[hdl/cdiv_pkg.sv]
package cdiv_pkg;

    // fixed widths of the stream fields
    localparam int FIELD_W  = 32;
    localparam int STATUS_W = 2;

    // status codes
    localparam logic [STATUS_W-1:0] ST_OK   = 2'd0;
    localparam logic [STATUS_W-1:0] ST_SAT  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_ZERO = 2'd2;

    // control that travels beside the data from the sum stage through the divider
    typedef struct packed {
        logic valid;
        logic zero;
    } t_ctrl;

endpackage

[hdl/cdiv_if.sv]
interface cdiv_in_if;
    logic                          valid;
    logic                          ready;
    logic [cdiv_pkg::FIELD_W-1:0] num_re;
    logic [cdiv_pkg::FIELD_W-1:0] num_im;
    logic [cdiv_pkg::FIELD_W-1:0] den_re;
    logic [cdiv_pkg::FIELD_W-1:0] den_im;

    modport source (output valid, num_re, num_im, den_re, den_im, input ready);
    modport sink   (input valid, num_re, num_im, den_re, den_im, output ready);
endinterface

interface cdiv_out_if;
    logic                           valid;
    logic                           ready;
    logic [cdiv_pkg::FIELD_W-1:0]  quot_re;
    logic [cdiv_pkg::FIELD_W-1:0]  quot_im;
    logic [cdiv_pkg::STATUS_W-1:0] status;

    modport source (output valid, quot_re, quot_im, status, input ready);
    modport sink   (input valid, quot_re, quot_im, status, output ready);
endinterface

[hdl/cdiv_front.sv]
module cdiv_front #(
    parameter int DW = 32
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_en,
    input  logic                         i_valid,
    input  logic [cdiv_pkg::FIELD_W-1:0] i_num_re,
    input  logic [cdiv_pkg::FIELD_W-1:0] i_num_im,
    input  logic [cdiv_pkg::FIELD_W-1:0] i_den_re,
    input  logic [cdiv_pkg::FIELD_W-1:0] i_den_im,
    output cdiv_pkg::t_ctrl              o_ctrl,
    output logic                         o_neg_re,
    output logic                         o_neg_im,
    output logic [2*DW-1:0]              o_mag_re,
    output logic [2*DW-1:0]              o_mag_im,
    output logic [2*DW-1:0]              o_den
);
    localparam int MW = 2 * DW;

    // stage 0: operands
    logic                 r_v0;
    logic signed [DW-1:0] r_a, r_b, r_c, r_d;
    // stage 1: products
    logic                 r_v1;
    logic signed [MW-1:0] r_ac, r_bd, r_bc, r_ad, r_cc, r_dd;
    // stage 2: sums
    cdiv_pkg::t_ctrl      r_ctrl;
    logic                 r_neg_re, r_neg_im;
    logic [MW-1:0]        r_mag_re, r_mag_im, r_den;

    logic signed [MW:0]   n_sre, n_sim;
    logic [MW-1:0]        n_den;

    always_comb begin
        n_sre = (MW+1)'(r_ac) + (MW+1)'(r_bd);
        n_sim = (MW+1)'(r_bc) - (MW+1)'(r_ad);
        n_den = r_cc + r_dd;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0   <= 1'b0;
            r_v1   <= 1'b0;
            r_ctrl <= '0;
        end else if (i_en) begin
            r_v0         <= i_valid;
            r_v1         <= r_v0;
            r_ctrl.valid <= r_v1;
            r_ctrl.zero  <= (n_den == '0);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_a      <= i_num_re[DW-1:0];
            r_b      <= i_num_im[DW-1:0];
            r_c      <= i_den_re[DW-1:0];
            r_d      <= i_den_im[DW-1:0];
            r_ac     <= r_a * r_c;
            r_bd     <= r_b * r_d;
            r_bc     <= r_b * r_c;
            r_ad     <= r_a * r_d;
            r_cc     <= r_c * r_c;
            r_dd     <= r_d * r_d;
            r_neg_re <= n_sre[MW];
            r_neg_im <= n_sim[MW];
            r_mag_re <= n_sre[MW] ? MW'(-n_sre) : MW'(n_sre);
            r_mag_im <= n_sim[MW] ? MW'(-n_sim) : MW'(n_sim);
            r_den    <= n_den;
        end
    end

    assign o_ctrl   = r_ctrl;
    assign o_neg_re = r_neg_re;
    assign o_neg_im = r_neg_im;
    assign o_mag_re = r_mag_re;
    assign o_mag_im = r_mag_im;
    assign o_den    = r_den;
endmodule

[hdl/cdiv_div.sv]
module cdiv_div #(
    parameter int DW = 32,
    parameter int FB = 16
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_en,
    input  cdiv_pkg::t_ctrl i_ctrl,
    input  logic            i_neg,
    input  logic [2*DW-1:0] i_mag,
    input  logic [2*DW-1:0] i_den,
    output cdiv_pkg::t_ctrl o_ctrl,
    output logic            o_neg,
    output logic            o_ovf,
    output logic [DW-1:0]   o_q,
    output logic            o_rnd
);
    localparam int MW = 2 * DW;
    localparam int PW = 3 * DW + FB + 1;

    cdiv_pkg::t_ctrl r_ctrl [0:DW];
    logic            r_neg  [0:DW];
    logic            r_ovf  [0:DW];
    logic [PW-1:0]   r_p    [0:DW];
    logic [MW-1:0]   r_d    [0:DW];
    logic [DW-1:0]   r_q    [0:DW];

    logic [PW-1:0]   n_num;

    assign n_num = PW'(i_mag) << FB;

    // entry stage: scaled numerator and the overflow test
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctrl[0] <= '0;
        end else if (i_en) begin
            r_ctrl[0] <= i_ctrl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p[0]   <= n_num;
            r_d[0]   <= i_den;
            r_neg[0] <= i_neg;
            r_ovf[0] <= n_num >= (PW'(i_den) << DW);
            r_q[0]   <= '0;
        end
    end

    // one quotient bit per stage, msb first
    for (genvar i = 0; i < DW; i++) begin : g_step
        logic [PW-1:0] w_t;
        logic          w_ge;

        assign w_t  = PW'(r_d[i]) << (DW - 1 - i);
        assign w_ge = r_p[i] >= w_t;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_ctrl[i+1] <= '0;
            end else if (i_en) begin
                r_ctrl[i+1] <= r_ctrl[i];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_p[i+1]   <= w_ge ? (r_p[i] - w_t) : r_p[i];
                r_d[i+1]   <= r_d[i];
                r_neg[i+1] <= r_neg[i];
                r_ovf[i+1] <= r_ovf[i];
                r_q[i+1]   <= {r_q[i][DW-2:0], w_ge};
            end
        end
    end

    assign o_ctrl = r_ctrl[DW];
    assign o_neg  = r_neg[DW];
    assign o_ovf  = r_ovf[DW];
    assign o_q    = r_q[DW];
    // round half away from zero: twice the remainder against the divisor
    assign o_rnd  = {r_p[DW], 1'b0} >= {1'b0, PW'(r_d[DW])};
endmodule

[hdl/cdiv_sat.sv]
module cdiv_sat #(
    parameter int DW = 32
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_en,
    input  cdiv_pkg::t_ctrl               i_ctrl,
    input  logic                          i_neg_re,
    input  logic                          i_ovf_re,
    input  logic [DW-1:0]                 i_q_re,
    input  logic                          i_rnd_re,
    input  logic                          i_neg_im,
    input  logic                          i_ovf_im,
    input  logic [DW-1:0]                 i_q_im,
    input  logic                          i_rnd_im,
    output logic                          o_valid,
    output logic [cdiv_pkg::FIELD_W-1:0]  o_quot_re,
    output logic [cdiv_pkg::FIELD_W-1:0]  o_quot_im,
    output logic [cdiv_pkg::STATUS_W-1:0] o_status
);
    localparam logic [DW:0] LIM_POS = (DW+1)'((64'd1 << (DW - 1)) - 64'd1);
    localparam logic [DW:0] LIM_NEG = (DW+1)'(64'd1 << (DW - 1));

    logic                          r_valid;
    logic [cdiv_pkg::FIELD_W-1:0]  r_quot_re, r_quot_im;
    logic [cdiv_pkg::STATUS_W-1:0] r_status;

    logic [DW:0]   n_qr_re, n_qr_im;
    logic          n_sat_re, n_sat_im;
    logic [DW-1:0] n_res_re, n_res_im;

    always_comb begin
        n_qr_re  = {1'b0, i_q_re} + (DW+1)'(i_rnd_re);
        n_qr_im  = {1'b0, i_q_im} + (DW+1)'(i_rnd_im);
        n_sat_re = i_ovf_re || (i_neg_re ? (n_qr_re > LIM_NEG) : (n_qr_re > LIM_POS));
        n_sat_im = i_ovf_im || (i_neg_im ? (n_qr_im > LIM_NEG) : (n_qr_im > LIM_POS));
        if (n_sat_re) begin
            n_res_re = i_neg_re ? DW'(LIM_NEG) : DW'(LIM_POS);
        end else begin
            n_res_re = i_neg_re ? DW'(-n_qr_re) : DW'(n_qr_re);
        end
        if (n_sat_im) begin
            n_res_im = i_neg_im ? DW'(LIM_NEG) : DW'(LIM_POS);
        end else begin
            n_res_im = i_neg_im ? DW'(-n_qr_im) : DW'(n_qr_im);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_ctrl.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (i_ctrl.zero) begin
                r_quot_re <= '0;
                r_quot_im <= '0;
                r_status  <= cdiv_pkg::ST_ZERO;
            end else begin
                r_quot_re <= cdiv_pkg::FIELD_W'(signed'(n_res_re));
                r_quot_im <= cdiv_pkg::FIELD_W'(signed'(n_res_im));
                r_status  <= (n_sat_re || n_sat_im) ? cdiv_pkg::ST_SAT : cdiv_pkg::ST_OK;
            end
        end
    end

    assign o_valid   = r_valid;
    assign o_quot_re = r_quot_re;
    assign o_quot_im = r_quot_im;
    assign o_status  = r_status;
endmodule

[hdl/complex_divide.sv]
// complex_divide: element-wise complex division (a+jb)/(c+jd) in signed fixed
// point, DATA_WIDTH bits with FRAC_BITS fraction bits (Q16.16 by default).
// One word is taken every clock cycle while the pipeline is not held; each result
// passes the operand, product and sum registers, the overflow test, one divider
// stage per quotient bit and the output register. Quotients are rounded to
// nearest, ties away from zero, and clip to the signed range with status 1; a
// zero denominator gives a zero quotient with status 2. The whole pipeline
// holds while the output word is not taken.
module complex_divide #(
    parameter int DATA_WIDTH = 32,
    parameter int FRAC_BITS  = 16
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    cdiv_in_if.sink    i_in,
    cdiv_out_if.source o_out
);
    localparam int MW = 2 * DATA_WIDTH;

    // front end: operands, products, sums and magnitudes
    cdiv_pkg::t_ctrl w_f_ctrl;
    logic            w_neg_re, w_neg_im;
    logic [MW-1:0]   w_mag_re, w_mag_im, w_den;

    // divider lanes
    cdiv_pkg::t_ctrl         w_re_ctrl, w_im_ctrl;
    logic                    w_re_neg, w_im_neg, w_re_ovf, w_im_ovf, w_re_rnd, w_im_rnd;
    logic [DATA_WIDTH-1:0]   w_re_q, w_im_q;
    cdiv_pkg::t_ctrl         w_im_tag;

    logic w_out_valid;
    logic w_en;

    // whole pipeline moves when the output register is free or being drained
    assign w_en       = !w_out_valid || o_out.ready;
    assign i_in.ready = w_en;

    cdiv_front #(.DW(DATA_WIDTH)) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (w_en),
        .i_valid  (i_in.valid),
        .i_num_re (i_in.num_re),
        .i_num_im (i_in.num_im),
        .i_den_re (i_in.den_re),
        .i_den_im (i_in.den_im),
        .o_ctrl   (w_f_ctrl),
        .o_neg_re (w_neg_re),
        .o_neg_im (w_neg_im),
        .o_mag_re (w_mag_re),
        .o_mag_im (w_mag_im),
        .o_den    (w_den)
    );

    // control rides both lanes; the empty tag ORed into the imaginary lane changes nothing
    assign w_im_tag = '0;

    cdiv_div #(.DW(DATA_WIDTH), .FB(FRAC_BITS)) u_div_re (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_ctrl  (w_f_ctrl),
        .i_neg   (w_neg_re),
        .i_mag   (w_mag_re),
        .i_den   (w_den),
        .o_ctrl  (w_re_ctrl),
        .o_neg   (w_re_neg),
        .o_ovf   (w_re_ovf),
        .o_q     (w_re_q),
        .o_rnd   (w_re_rnd)
    );

    cdiv_div #(.DW(DATA_WIDTH), .FB(FRAC_BITS)) u_div_im (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_ctrl  (w_im_tag | w_f_ctrl),
        .i_neg   (w_neg_im),
        .i_mag   (w_mag_im),
        .i_den   (w_den),
        .o_ctrl  (w_im_ctrl),
        .o_neg   (w_im_neg),
        .o_ovf   (w_im_ovf),
        .o_q     (w_im_q),
        .o_rnd   (w_im_rnd)
    );

    // output register: rounding, saturation, zero denominator override
    cdiv_sat #(.DW(DATA_WIDTH)) u_sat (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_en      (w_en),
        .i_ctrl    (w_re_ctrl & w_im_ctrl),
        .i_neg_re  (w_re_neg),
        .i_ovf_re  (w_re_ovf),
        .i_q_re    (w_re_q),
        .i_rnd_re  (w_re_rnd),
        .i_neg_im  (w_im_neg),
        .i_ovf_im  (w_im_ovf),
        .i_q_im    (w_im_q),
        .i_rnd_im  (w_im_rnd),
        .o_valid   (w_out_valid),
        .o_quot_re (o_out.quot_re),
        .o_quot_im (o_out.quot_im),
        .o_status  (o_out.status)
    );

    assign o_out.valid = w_out_valid;
endmodule
